/* rtl/core/spns_pkg.sv */
// shared types, constants and helpers for the strict priority scheduler
`default_nettype none
package spns_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int LEVELS      = 4;
  localparam int CUTOFF_RST  = 100;
  localparam int CMDQ_DEPTH  = 4;

  localparam int LVL_W      = $clog2(LEVELS);
  localparam int PTR_W      = $clog2(QUEUE_DEPTH);
  localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int MEM_DEPTH  = LEVELS * QUEUE_DEPTH;
  localparam int ADDR_W     = $clog2(MEM_DEPTH);
  localparam int ENTRY_W    = 24;
  localparam int CQ_PTR_W   = $clog2(CMDQ_DEPTH);
  localparam int CQ_CNT_W   = $clog2(CMDQ_DEPTH + 1);

  localparam logic MODE_ARRIVAL = 1'b0;
  localparam logic MODE_TICK    = 1'b1;

  typedef enum logic [1:0] {
    KIND_ACCEPTED = 2'd0,
    KIND_FULL     = 2'd1,
    KIND_BAD_PRIO = 2'd2,
    KIND_TICK     = 2'd3
  } kind_t;

  typedef enum logic {
    BK_RUN,
    BK_FETCH
  } back_state_t;

  typedef struct packed {
    logic        mode;
    logic [7:0]  job_id;
    logic [2:0]  job_priority;
    logic [15:0] burst_length;
  } req_t;

  typedef struct packed {
    kind_t       result_kind;
    logic [15:0] now_time;
    logic        busy_res;
    logic [7:0]  running_id;
    logic        started_now;
    logic        finished_now;
    logic        all_done;
  } res_t;

  // decoded request as it waits between front and back
  typedef struct packed {
    logic             is_tick;
    logic             bad_prio;
    logic [LVL_W-1:0] level;
    logic [7:0]       job_id;
    logic [15:0]      burst;
  } cmd_t;

  function automatic logic [ADDR_W-1:0] fifo_addr(input logic [LVL_W-1:0] lvl,
                                                  input logic [PTR_W-1:0] ptr);
    return ADDR_W'(lvl) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(ptr);
  endfunction

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
    return (ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
  endfunction

endpackage
`default_nettype wire

/* rtl/core/spns_ram.sv */
// generic single write port ram with registered read
`default_nettype none
module spns_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* rtl/core/spns_front.sv */
// front end: takes requests and decodes mode and priority level
`default_nettype none
module spns_front
  import spns_pkg::*;
(
  input  wire logic start,
  input  wire logic q_full,
  input  wire req_t req,
  output logic      push,
  output cmd_t      cmd
);

  logic [3:0] prio_ext;

  assign prio_ext = {1'b0, req.job_priority};
  assign push     = start && !q_full;

  always_comb begin
    cmd.is_tick  = (req.mode == MODE_TICK);
    cmd.bad_prio = (prio_ext < 4'd1) || (prio_ext > 4'(LEVELS));
    cmd.level    = LVL_W'(req.job_priority - 3'd1);
    cmd.job_id   = req.job_id;
    cmd.burst    = req.burst_length;
  end

endmodule
`default_nettype wire

/* rtl/core/spns_cmdq.sv */
// short command queue between front and back
`default_nettype none
module spns_cmdq
  import spns_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  input  wire logic pop,
  output cmd_t      head,
  output logic      empty,
  output logic      full
);

  cmd_t                entries [CMDQ_DEPTH];
  logic [CQ_PTR_W-1:0] wptr;
  logic [CQ_PTR_W-1:0] rptr;
  logic [CQ_CNT_W-1:0] count;

  assign empty = (count == '0);
  assign full  = (count == CQ_CNT_W'(CMDQ_DEPTH));
  assign head  = entries[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == CQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wptr + CQ_PTR_W'(1);
      end
      if (pop) begin
        rptr <= (rptr == CQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rptr + CQ_PTR_W'(1);
      end
      count <= count + CQ_CNT_W'(push) - CQ_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_cmd;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= CQ_CNT_W'(CMDQ_DEPTH))
    else $error("command queue count past depth");
`endif

endmodule
`default_nettype wire

/* rtl/core/spns_back.sv */
// back end: level fifos, tick counter, running job and result register
`default_nettype none
module spns_back
  import spns_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cmd_t        cmd,
  input  wire logic        q_empty,
  input  wire logic [15:0] cutoff_time,
  output logic             pop,
  output logic             result_valid,
  output res_t             result
);

  back_state_t state, state_next;

  logic [PTR_W-1:0] heads  [LEVELS];
  logic [PTR_W-1:0] tails  [LEVELS];
  logic [CNT_W-1:0] counts [LEVELS];
  logic [PTR_W-1:0] heads_next  [LEVELS];
  logic [PTR_W-1:0] tails_next  [LEVELS];
  logic [CNT_W-1:0] counts_next [LEVELS];

  logic [15:0] tick_count, tick_count_next;
  logic        run_valid, run_valid_next;
  logic [7:0]  run_job, run_job_next;
  logic [15:0] run_elapsed, run_elapsed_next;
  logic [15:0] run_burst, run_burst_next;
  logic        result_valid_next;
  res_t        result_next;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  logic [LVL_W-1:0] sel_level;
  logic             any_queued;
  logic [LVL_W-1:0] lvl;
  logic             start_fetch;
  logic [15:0]      tick_inc;

  // highest priority nonempty level, level 0 first
  always_comb begin
    sel_level  = '0;
    any_queued = 1'b0;
    for (int l = LEVELS - 1; l >= 0; l--) begin
      if (counts[l] != '0) begin
        sel_level  = LVL_W'(l);
        any_queued = 1'b1;
      end
    end
  end

  assign lvl         = cmd.is_tick ? sel_level : cmd.level;
  assign tick_inc    = (tick_count != 16'hFFFF) ? tick_count + 16'd1 : tick_count;
  assign start_fetch = (state == BK_RUN) && !q_empty && cmd.is_tick && !run_valid &&
                       (tick_count < cutoff_time) && any_queued;
  assign ram_waddr   = fifo_addr(lvl, tails[lvl]);
  assign ram_raddr   = fifo_addr(lvl, heads[lvl]);

  spns_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(MEM_DEPTH)
  ) u_fifo_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata({cmd.job_id, cmd.burst}),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      BK_RUN: begin
        if (start_fetch) begin
          state_next = BK_FETCH;
        end
      end
      BK_FETCH: state_next = BK_RUN;
      default:  state_next = BK_RUN;
    endcase
  end

  always_comb begin
    logic [15:0] elapsed_inc;
    elapsed_inc       = (run_elapsed != 16'hFFFF) ? run_elapsed + 16'd1 : run_elapsed;
    heads_next        = heads;
    tails_next        = tails;
    counts_next       = counts;
    tick_count_next   = tick_count;
    run_valid_next    = run_valid;
    run_job_next      = run_job;
    run_elapsed_next  = run_elapsed;
    run_burst_next    = run_burst;
    pop               = 1'b0;
    ram_we            = 1'b0;
    result_valid_next = 1'b0;
    result_next       = '0;
    result_next.now_time = tick_count;
    case (state)
      BK_RUN: begin
        if (!q_empty) begin
          pop = 1'b1;
          if (!cmd.is_tick) begin
            result_valid_next = 1'b1;
            if (cmd.bad_prio) begin
              result_next.result_kind = KIND_BAD_PRIO;
            end else if (counts[lvl] >= CNT_W'(QUEUE_DEPTH)) begin
              result_next.result_kind = KIND_FULL;
            end else begin
              ram_we                  = 1'b1;
              tails_next[lvl]         = ptr_inc(tails[lvl]);
              counts_next[lvl]        = counts[lvl] + CNT_W'(1);
              result_next.result_kind = KIND_ACCEPTED;
            end
          end else if (run_valid) begin
            result_valid_next        = 1'b1;
            result_next.result_kind  = KIND_TICK;
            result_next.busy_res     = 1'b1;
            result_next.running_id   = run_job;
            result_next.finished_now = (elapsed_inc >= run_burst);
            run_elapsed_next         = elapsed_inc;
            run_valid_next           = !(elapsed_inc >= run_burst);
            tick_count_next          = tick_inc;
          end else if (tick_count >= cutoff_time) begin
            // schedule over: drop everything still queued
            for (int l = 0; l < LEVELS; l++) begin
              heads_next[l]  = '0;
              tails_next[l]  = '0;
              counts_next[l] = '0;
            end
            result_valid_next       = 1'b1;
            result_next.result_kind = KIND_TICK;
            result_next.all_done    = 1'b1;
            tick_count_next         = tick_inc;
          end else if (any_queued) begin
            // head entry comes out of the ram next cycle
            heads_next[lvl]  = ptr_inc(heads[lvl]);
            counts_next[lvl] = counts[lvl] - CNT_W'(1);
          end else begin
            result_valid_next       = 1'b1;
            result_next.result_kind = KIND_TICK;
            tick_count_next         = tick_inc;
          end
        end
      end
      BK_FETCH: begin
        // job starts and runs its first tick; burst of zero or one ends here
        run_job_next             = ram_rdata[23:16];
        run_burst_next           = ram_rdata[15:0];
        run_elapsed_next         = 16'd1;
        run_valid_next           = !(ram_rdata[15:0] <= 16'd1);
        result_valid_next        = 1'b1;
        result_next.result_kind  = KIND_TICK;
        result_next.busy_res     = 1'b1;
        result_next.running_id   = ram_rdata[23:16];
        result_next.started_now  = 1'b1;
        result_next.finished_now = (ram_rdata[15:0] <= 16'd1);
        tick_count_next          = tick_inc;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= BK_RUN;
      tick_count   <= '0;
      run_valid    <= 1'b0;
      run_job      <= '0;
      run_elapsed  <= '0;
      run_burst    <= '0;
      result_valid <= 1'b0;
      for (int l = 0; l < LEVELS; l++) begin
        heads[l]  <= '0;
        tails[l]  <= '0;
        counts[l] <= '0;
      end
    end else begin
      state        <= state_next;
      tick_count   <= tick_count_next;
      run_valid    <= run_valid_next;
      run_job      <= run_job_next;
      run_elapsed  <= run_elapsed_next;
      run_burst    <= run_burst_next;
      result_valid <= result_valid_next;
      heads        <= heads_next;
      tails        <= tails_next;
      counts       <= counts_next;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

`ifndef SYNTHESIS
  a_fetch_one_cycle: assert property (@(posedge clk) disable iff (rst)
    state == BK_FETCH |=> state == BK_RUN)
    else $error("fetch state held longer than one cycle");
  a_fetch_gives_start: assert property (@(posedge clk) disable iff (rst)
    state == BK_FETCH |=> result_valid && result.started_now && result.busy_res)
    else $error("fetch did not produce a start report");
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.all_done |-> !result.busy_res && !$past(run_valid))
    else $error("schedule over reported while a job ran");
`endif

endmodule
`default_nettype wire

/* rtl/core/strict_priority_nonpreemptive_scheduler_unit.sv */
// top level of the non-preemptive strict priority job scheduler
`default_nettype none
// usage
//   a request is taken at a rising edge with start high and busy low; req.mode
//   selects a job arrival (id, priority 1 highest .. LEVELS lowest, burst) or
//   one time tick
//   every request gives exactly one result: result_valid is high for one cycle
//   with the result struct; there is no way to hold results off, so the
//   consumer must take each one as it comes
//   cfg_we with cfg_wdata writes the cutoff tick; write it only while idle
// timing
//   a taken request enters the command queue; the back end pops it and the
//   result is registered; a tick that starts a queued job also passes the
//   fetch state, for the registered read of the queue head from the job ram
//   so the back end retires one request per clock while the queue is not
//   empty, but not on such a tick; a four deep command queue lets requests
//   arrive while the back end is fetching, and busy is high while it is full
// reset
//   rst is synchronous, active high: queues empty, tick count zero, no job
//   running, cutoff back to 100; the job ram keeps old contents, which are
//   never read before being written, so no clearing pass is needed
module strict_priority_nonpreemptive_scheduler_unit
  import spns_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire req_t        req,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,
  output logic             result_valid,
  output res_t             result
);

  // cutoff register, the only configuration state
  logic [15:0] cutoff_time;

  // front to queue
  logic push;
  cmd_t push_cmd;

  // queue to back
  cmd_t head_cmd;
  logic q_empty;
  logic q_full;
  logic pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cutoff_time <= 16'(CUTOFF_RST);
    end else if (cfg_we) begin
      cutoff_time <= cfg_wdata;
    end
  end

  // busy only reflects room in the command queue, not what the back end does
  assign busy = q_full;

  spns_front u_front (
    .start (start),
    .q_full(q_full),
    .req   (req),
    .push  (push),
    .cmd   (push_cmd)
  );

  spns_cmdq u_cmdq (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_cmd(push_cmd),
    .pop     (pop),
    .head    (head_cmd),
    .empty   (q_empty),
    .full    (q_full)
  );

  // back end owns the level fifos, the run state and the result register
  spns_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd         (head_cmd),
    .q_empty     (q_empty),
    .cutoff_time (cutoff_time),
    .pop         (pop),
    .result_valid(result_valid),
    .result      (result)
  );

endmodule
`default_nettype wire

/* tb/tb_strict_priority_nonpreemptive_scheduler_unit.sv */
// self-checking testbench for the strict priority non-preemptive scheduler
`timescale 1ns / 100ps

module tb_strict_priority_nonpreemptive_scheduler_unit;
  import spns_pkg::*;

  // clock, reset and block ports
  logic        clk;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  req_t        req = '0;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        result_valid;
  res_t        result;

  strict_priority_nonpreemptive_scheduler_unit dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .req          (req),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .result_valid (result_valid),
    .result       (result)
  );

  // 100 MHz clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop in case the block hangs or stops answering
  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end

  // scheduler shadow state, kept in step with every accepted request
  logic [23:0] queued_jobs [LEVELS][QUEUE_DEPTH];
  int q_head  [LEVELS];
  int q_tail  [LEVELS];
  int q_count [LEVELS];
  int tick_now;
  bit job_active;
  logic [7:0] active_id;
  int active_elapsed;
  int active_burst;
  int cutoff_reg;

  // reports the block still owes us, oldest first
  res_t pending_reports [$];

  // run bookkeeping
  int mismatch_count = 0;
  int gap_pct = 0;
  int n_requests = 0;
  int n_started = 0;
  int n_finished = 0;
  int n_full = 0;
  int n_bad_prio = 0;
  int n_flush = 0;
  int n_cutoff_writes = 0;

  function automatic void empty_queues();
    for (int l = 0; l < LEVELS; l++) begin
      q_head[l]  = 0;
      q_tail[l]  = 0;
      q_count[l] = 0;
    end
  endfunction

  // state right after reset
  function automatic void reset_schedule();
    empty_queues();
    tick_now       = 0;
    job_active     = 1'b0;
    active_id      = '0;
    active_elapsed = 0;
    active_burst   = 0;
    cutoff_reg     = CUTOFF_RST;
  endfunction

  // expected report for one request; advances the shadow state
  function automatic res_t schedule_step(req_t r);
    res_t o;
    int   lvl;
    bit   picked;
    o          = '0;
    picked     = 1'b0;
    o.now_time = 16'(tick_now);
    if (r.mode == MODE_ARRIVAL) begin
      if (r.job_priority < 1 || r.job_priority > LEVELS) begin
        // priority outside 1..LEVELS is refused and the job dropped
        o.result_kind = KIND_BAD_PRIO;
        n_bad_prio++;
      end else begin
        // priority 1 lands in level 0, the lowest priority in the last level
        lvl = r.job_priority - 1;
        if (q_count[lvl] >= QUEUE_DEPTH) begin
          o.result_kind = KIND_FULL;
          n_full++;
        end else begin
          queued_jobs[lvl][q_tail[lvl]] = {r.job_id, r.burst_length};
          q_tail[lvl] = (q_tail[lvl] + 1) % QUEUE_DEPTH;
          q_count[lvl]++;
          o.result_kind = KIND_ACCEPTED;
        end
      end
    end else begin
      o.result_kind = KIND_TICK;
      if (!job_active) begin
        if (tick_now >= cutoff_reg) begin
          // idle at or past the cutoff: everything queued is thrown away
          empty_queues();
          o.all_done = 1'b1;
          n_flush++;
        end else begin
          // highest nonempty level wins, oldest job first
          for (lvl = 0; lvl < LEVELS; lvl++) begin
            if (!picked && q_count[lvl] != 0) begin
              active_id      = queued_jobs[lvl][q_head[lvl]][23:16];
              active_burst   = queued_jobs[lvl][q_head[lvl]][15:0];
              active_elapsed = 0;
              job_active     = 1'b1;
              q_head[lvl]    = (q_head[lvl] + 1) % QUEUE_DEPTH;
              q_count[lvl]--;
              o.started_now  = 1'b1;
              picked         = 1'b1;
              n_started++;
            end
          end
        end
      end
      if (job_active) begin
        // a zero burst still takes one tick, since elapsed is at least 1 here
        o.busy_res   = 1'b1;
        o.running_id = active_id;
        if (active_elapsed < 65535) active_elapsed++;
        if (active_elapsed >= active_burst) begin
          o.finished_now = 1'b1;
          job_active     = 1'b0;
          n_finished++;
        end
      end
      if (tick_now < 65535) tick_now++;
    end
    return o;
  endfunction

  // one request: hold start until the block takes it, then maybe pause
  task automatic issue_request(req_t r);
    if (!start) start <= 1'b1;
    req <= r;
    do begin
      @(posedge clk);
    end while (busy);
    pending_reports.push_back(schedule_step(r));
    n_requests++;
    if ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      do begin
        @(posedge clk);
      end while ($urandom_range(99) < gap_pct);
    end
  endtask

  // stop sending and wait for every owed report, plus a little settling time
  task automatic drain_requests();
    if (start) start <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // only called with the block drained
  task automatic write_cutoff(int value);
    cfg_wdata <= 16'(value);
    cfg_we    <= 1'b1;
    @(posedge clk);
    cutoff_reg = value;
    n_cutoff_writes++;
    cfg_we <= 1'b0;
  endtask

  function automatic req_t make_arrival(logic [7:0] id, logic [2:0] prio,
                                        logic [15:0] burst);
    req_t r;
    r.mode         = MODE_ARRIVAL;
    r.job_id       = id;
    r.job_priority = prio;
    r.burst_length = burst;
    return r;
  endfunction

  // tick with junk in the unused fields
  function automatic req_t make_tick();
    req_t r;
    r              = req_t'($urandom());
    r.mode         = MODE_TICK;
    return r;
  endfunction

  // mostly well-formed traffic with short bursts; bad priorities carry full
  // range ids and bursts so every field bit toggles
  function automatic req_t random_request();
    req_t r;
    int   pick;
    if ($urandom_range(99) < 45) return make_tick();
    r.mode   = MODE_ARRIVAL;
    r.job_id = 8'($urandom_range(255));
    if ($urandom_range(99) < 90) begin
      r.job_priority = 3'($urandom_range(LEVELS, 1));
      // long bursts would stall the schedule, so accepted jobs stay short
      if ($urandom_range(99) < 90) r.burst_length = 16'($urandom_range(4));
      else r.burst_length = 16'($urandom_range(40, 5));
    end else begin
      pick = $urandom_range(3);
      r.job_priority = (pick == 0) ? 3'd0 : 3'(pick + LEVELS);
      r.burst_length = 16'($urandom_range(65535));
    end
    return r;
  endfunction

  task automatic compare_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("mismatch at %0t: %s expected %0h got %0h", $realtime, name, want, got);
    end
  endtask

  // every report is checked against the oldest owed one
  always @(posedge clk) begin
    res_t want;
    if (!rst && result_valid) begin
      if (pending_reports.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected report at %0t: kind %0d id %0h", $realtime,
                   result.result_kind, result.running_id);
      end else begin
        want = pending_reports.pop_front();
        compare_field("result_kind", 16'(want.result_kind), 16'(result.result_kind));
        compare_field("now_time", want.now_time, result.now_time);
        compare_field("busy_res", 16'(want.busy_res), 16'(result.busy_res));
        compare_field("running_id", 16'(want.running_id), 16'(result.running_id));
        compare_field("started_now", 16'(want.started_now), 16'(result.started_now));
        compare_field("finished_now", 16'(want.finished_now), 16'(result.finished_now));
        compare_field("all_done", 16'(want.all_done), 16'(result.all_done));
      end
    end
  end

  // every level, refusals, strict order, zero burst and idle ticks
  task automatic test_priority_order();
    issue_request(make_tick());
    issue_request(make_arrival(8'h04, 3'd4, 16'd1));
    issue_request(make_arrival(8'h03, 3'd3, 16'd0));
    issue_request(make_arrival(8'hFF, 3'd1, 16'd2));
    issue_request(make_arrival(8'h00, 3'd2, 16'd1));
    issue_request(make_arrival(8'hFF, 3'd0, 16'hFFFF));
    issue_request(make_arrival(8'h00, 3'd7, 16'h0000));
    issue_request(make_arrival(8'hA5, 3'd5, 16'h5A5A));
    repeat (6) issue_request(make_tick());
    drain_requests();
  endtask

  // running job outlives the cutoff, late arrival gets flushed
  task automatic test_cutoff();
    issue_request(make_arrival(8'h81, 3'd2, 16'd3));
    issue_request(make_tick());
    drain_requests();
    write_cutoff(0);
    repeat (2) issue_request(make_tick());
    issue_request(make_arrival(8'h5A, 3'd4, 16'hFFFF));
    repeat (2) issue_request(make_tick());
    drain_requests();
  endtask

  // one level overfilled while nothing can start, then flushed
  task automatic test_queue_full();
    for (int i = 0; i <= QUEUE_DEPTH; i++)
      issue_request(make_arrival(8'(i + 8'h40), 3'd3, 16'(i)));
    issue_request(make_tick());
    drain_requests();
  endtask

  // random traffic in segments, each under its own cutoff setting
  task automatic test_random_phase(int phase, int idle_pct, int per_segment);
    int value;
    gap_pct = idle_pct;
    for (int seg = 0; seg < 4; seg++) begin
      case ((seg + phase) % 4)
        0: value = tick_now + $urandom_range(300, 40);
        1: value = 65535;
        2: value = tick_now + $urandom_range(60, 5);
        default: value = 0;
      endcase
      if (value > 65535) value = 65535;
      write_cutoff(value);
      repeat (per_segment) issue_request(random_request());
      drain_requests();
    end
  endtask

  // long burst runs to its end alone, then a zero burst takes a single tick
  task automatic test_long_burst();
    gap_pct = 0;
    while (job_active) issue_request(make_tick());
    drain_requests();
    write_cutoff(0);
    // idle tick at the cutoff empties whatever is still queued
    issue_request(make_tick());
    drain_requests();
    write_cutoff(65535);
    issue_request(make_arrival(8'hC3, 3'd1, 16'd250));
    do begin
      issue_request(make_tick());
    end while (job_active);
    repeat (2) issue_request(make_tick());
    issue_request(make_arrival(8'h3C, 3'd1, 16'd0));
    issue_request(make_tick());
    drain_requests();
  endtask

  initial begin
    reset_schedule();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_priority_order();
    test_cutoff();
    test_queue_full();
    // sender idles rarely, then often, then never
    test_random_phase(0, 13, 100);
    test_random_phase(1, 72, 100);
    test_random_phase(2, 0, 100);
    test_long_burst();

    repeat (10) @(posedge clk);
    $display("covered %0d requests: %0d jobs started, %0d finished, %0d full, %0d bad priority",
             n_requests, n_started, n_finished, n_full, n_bad_prio);
    $display("%0d cutoff flushes over %0d cutoff settings, tick count ended at %0d",
             n_flush, n_cutoff_writes, tick_now);
    if (mismatch_count == 0 && pending_reports.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/spns_pkg.sv
rtl/core/spns_ram.sv
rtl/core/spns_front.sv
rtl/core/spns_cmdq.sv
rtl/core/spns_back.sv
rtl/core/strict_priority_nonpreemptive_scheduler_unit.sv
tb/tb_strict_priority_nonpreemptive_scheduler_unit.sv
